// ===== hdl/pidl_pkg.sv =====
// Package for the positional insert/delete list.
// Holds sizes, command and status codes, and controller/datapath link types.
// No dependencies.
`default_nettype none

package pidl_pkg;

    // List size and derived widths
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int ST_W     = 2;
    localparam int LEN_W    = 5;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_GET    = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    // Status codes
    typedef enum logic [ST_W-1:0] {
        ST_DONE   = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic              load;     // capture the request fields
        logic              exec;     // latch the result
        logic              do_append;
        logic              do_insert;
        logic              do_delete;
        logic              do_get;
        logic              do_clear;
        logic [ST_W-1:0]   status;
    } ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic              pos_gt_cnt;
        logic              pos_ge_cnt;
        logic              full;
    } flags_t;

endpackage

`default_nettype wire

// ===== hdl/pidl_ctrl.sv =====
// Sequencer for the positional insert/delete list.
// Decodes each request and steers the datapath; uses pidl_pkg.
`default_nettype none

module pidl_ctrl
    import pidl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  wire logic   out_ready,
    input  wire flags_t flags,
    output ctl_t        ctl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_RESP);

    // Decode the held request into datapath operations and a status code
    always_comb
    begin
        ctl        = '0;
        ctl.status = ST_DONE;
        ctl.load   = in_valid && (state_reg == S_IDLE);
        ctl.exec   = (state_reg == S_EXEC);
        if (state_reg == S_EXEC)
        begin
            unique case (flags.cmd)
                CMD_APPEND:
                begin
                    if (flags.full)
                        ctl.status = ST_FULL;
                    else
                        ctl.do_append = 1'b1;
                end
                CMD_INSERT:
                begin
                    if (flags.pos_gt_cnt)
                        ctl.status = ST_BADPOS;
                    else if (flags.full)
                        ctl.status = ST_FULL;
                    else
                        ctl.do_insert = 1'b1;
                end
                CMD_DELETE:
                begin
                    if (flags.pos_ge_cnt)
                        ctl.status = ST_BADPOS;
                    else
                        ctl.do_delete = 1'b1;
                end
                CMD_GET:
                begin
                    if (flags.pos_ge_cnt)
                        ctl.status = ST_BADPOS;
                    else
                        ctl.do_get = 1'b1;
                end
                CMD_CLEAR:
                begin
                    ctl.do_clear = 1'b1;
                end
                default:
                begin
                    ctl.status = ST_DONE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pidl_datapath.sv =====
// Datapath for the positional insert/delete list: request registers,
// shifting cell row, element count and result registers; uses pidl_pkg.
`default_nettype none

module pidl_datapath
    import pidl_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [CMD_W-1:0]         command,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire logic [POS_W-1:0]         position,
    input  wire ctl_t                     ctl,
    output flags_t                        flags,
    output logic signed [DATA_W-1:0]      read_value,
    output logic [ST_W-1:0]               status,
    output logic [LEN_W-1:0]              length
);

    logic [CMD_W-1:0]         cmd_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic signed [DATA_W-1:0] cells [CAPACITY];
    logic signed [DATA_W-1:0] rd_reg;
    logic [ST_W-1:0]          st_reg;
    logic [LEN_W-1:0]         len_reg;
    logic [CMP_W-1:0]         pos_x;
    logic [CMP_W-1:0]         cnt_x;

    // Hold the accepted request
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= command;
            val_reg <= value;
            pos_reg <= position;
        end
    end

    assign pos_x = CMP_W'(pos_reg);
    assign cnt_x = CMP_W'(cnt_reg);

    // Report position checks and fullness
    assign flags.cmd        = cmd_reg;
    assign flags.pos_gt_cnt = (pos_x > cnt_x);
    assign flags.pos_ge_cnt = (pos_x >= cnt_x);
    assign flags.full       = (cnt_reg == CNT_W'(CAPACITY));

    // Update the element count
    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.do_append || ctl.do_insert)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (ctl.do_delete)
            cnt_next = cnt_reg - CNT_W'(1);
        else if (ctl.do_clear)
            cnt_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // Write the new value or shift each cell from its neighbor in parallel
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CMP_W-1:0] IDX_I = CMP_W'(i);
        localparam logic [CMP_W-1:0] IDX_N = CMP_W'(i + 1);
        logic signed [DATA_W-1:0] lower;
        logic signed [DATA_W-1:0] upper;

        if (i > 0)
        begin : g_lo
            assign lower = cells[i-1];
        end
        else
        begin : g_lo0
            assign lower = val_reg;
        end

        if (i < CAPACITY - 1)
        begin : g_up
            assign upper = cells[i+1];
        end
        else
        begin : g_upn
            assign upper = cells[i];
        end

        always_ff @(posedge clk)
        begin
            if (ctl.do_append && (IDX_I == cnt_x))
                cells[i] <= val_reg;
            else if (ctl.do_insert && (IDX_I == pos_x))
                cells[i] <= val_reg;
            else if (ctl.do_insert && (IDX_I > pos_x) && (IDX_I <= cnt_x))
                cells[i] <= lower;
            else if (ctl.do_delete && (IDX_I >= pos_x) && (IDX_N < cnt_x))
                cells[i] <= upper;
        end
    end

    // Latch the result
    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            rd_reg  <= ctl.do_get ? cells[IDX_W'(pos_reg)] : '0;
            st_reg  <= ctl.status;
            len_reg <= LEN_W'(cnt_next);
        end
    end

    assign read_value = rd_reg;
    assign status     = st_reg;
    assign length     = len_reg;

endmodule

`default_nettype wire

// ===== hdl/positional_insert_delete_list.sv =====
// Top level of the positional insert/delete list.
// Joins pidl_ctrl and pidl_datapath; uses pidl_pkg.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------
//  request  | in_valid / in_ready   | command, value, position
//  result   | out_valid / out_ready | read_value, status, length
//
// A request passes through capture, execute with all cells shifting
// at once, then the result is held until taken. The three-state sequencer
// sets these steps; one request is in flight at a time.
// Reset clears the count and the sequencer; cell contents are not cleared.
// A stalled result holds its value and blocks the next request.
`default_nettype none

module positional_insert_delete_list
    import pidl_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [CMD_W-1:0]         command,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire logic [POS_W-1:0]         position,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [DATA_W-1:0]      read_value,
    output logic [ST_W-1:0]               status,
    output logic [LEN_W-1:0]              length
);

    ctl_t   ctl;
    flags_t flags;

    pidl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .flags     (flags),
        .ctl       (ctl)
    );

    pidl_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .command    (command),
        .value      (value),
        .position   (position),
        .ctl        (ctl),
        .flags      (flags),
        .read_value (read_value),
        .status     (status),
        .length     (length)
    );

endmodule

`default_nettype wire
